FILE: hw/rtl/rgbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbs_pkg
// Types, constants and per-channel blend functions of the RGB555 5:8 scaler.
// ----------------------------------------------------------------------------
package rgbs_pkg;

    localparam int PIXEL_W    = 15;
    localparam int GROUP_SIZE = 5;
    localparam int GROUP_OUT  = 8;

    typedef logic [PIXEL_W-1:0] pixel_t;
    typedef logic [2:0]         weight_t;

    localparam pixel_t CHANNEL_MASK = 15'h7BDE;

    // blend weights in eighths toward the second pixel
    localparam weight_t W_1_8 = 3'd1;
    localparam weight_t W_2_8 = 3'd2;
    localparam weight_t W_3_8 = 3'd3;
    localparam weight_t W_4_8 = 3'd4;
    localparam weight_t W_5_8 = 3'd5;
    localparam weight_t W_6_8 = 3'd6;
    localparam weight_t W_7_8 = 3'd7;

    // per-channel floor average
    function automatic pixel_t avg15(input pixel_t a, input pixel_t b);
        avg15 = (a & b) + (((a ^ b) & CHANNEL_MASK) >> 1);
    endfunction

    function automatic pixel_t blend8(input pixel_t a, input pixel_t b, input weight_t w);
        pixel_t h;
        pixel_t r;
        h = avg15(a, b);
        case (w)
            W_1_8:   r = avg15(a, avg15(a, h));
            W_2_8:   r = avg15(a, h);
            W_3_8:   r = avg15(avg15(a, h), h);
            W_4_8:   r = h;
            W_5_8:   r = avg15(h, avg15(h, b));
            W_6_8:   r = avg15(h, b);
            default: r = avg15(avg15(h, b), b);
        endcase
        if (a == b)
        begin
            r = a;
        end
        blend8 = r;
    endfunction

endpackage

FILE: hw/rtl/rgb555_horizontal_5to8_scaler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb555_horizontal_5to8_scaler
// Horizontal 5:8 linear upscaler for RGB555 lines.
//
//   channel | signals                                   | moves
//   --------+-------------------------------------------+---------------------
//   src     | src_valid, src_ready, src_pixel           | one source pixel
//   out     | out_valid, out_ready, out_pixel,          | one output pixel
//           | group_last, line_end                      |
//
// The request that closes a group loads all eight blended pixels into an
// output shift bank in that cycle; the bank then delivers one pixel per
// cycle while out_ready is high, and each group of five requests yields
// eight output pixels. A closing request waits while the bank holds any
// pixel other than a final one that leaves in the same cycle.
// Reset clears the line position and empties the bank; the group registers
// are written before use.
// ----------------------------------------------------------------------------
module rgb555_horizontal_5to8_scaler #(
    parameter int LINE_PIXELS = 160
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_valid,
    output logic              src_ready,
    input  rgbs_pkg::pixel_t  src_pixel,
    output logic              out_valid,
    input  logic              out_ready,
    output rgbs_pkg::pixel_t  out_pixel,
    output logic              group_last,
    output logic              line_end
);
    import rgbs_pkg::*;

    localparam int POS_W    = $clog2(LINE_PIXELS);
    localparam int FULL_END = (LINE_PIXELS / GROUP_SIZE) * GROUP_SIZE;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_PIXELS - 1);
    localparam logic [POS_W-1:0] POS_FULL = POS_W'(FULL_END);
    localparam logic [POS_W-1:0] POS_ONE  = POS_W'(1);
    localparam logic [2:0]       SLOT_LAST = 3'(GROUP_SIZE - 1);
    localparam logic [2:0]       IDX_LAST  = 3'(GROUP_OUT - 1);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [2:0]       slot_reg, slot_next;
    logic             busy_reg, busy_next;
    logic [2:0]       idx_reg, idx_next;
    logic             last_reg, last_next;

    pixel_t [GROUP_SIZE-1:0] group_reg;
    pixel_t [GROUP_SIZE-1:0] blend_group;
    pixel_t [GROUP_OUT-1:0]  blend_pixels;
    pixel_t [GROUP_OUT-1:0]  bank_reg, bank_next;

    logic src_fire, out_fire;
    logic close_mid, close_end, will_close, bank_free, load;

    // group closed by the first pixel of the next group
    assign close_mid  = (slot_reg == 3'd0) && (pos_reg != '0)
                        && (({1'b0, pos_reg}) <= ({1'b0, POS_FULL}));
    // line ends exactly on a group boundary
    assign close_end  = (pos_reg == POS_LAST) && (slot_reg == SLOT_LAST);
    assign will_close = close_mid || close_end;

    assign out_fire  = busy_reg && out_ready;
    assign bank_free = !busy_reg || (out_fire && (idx_reg == IDX_LAST));
    assign src_ready = !will_close || bank_free;
    assign src_fire  = src_valid && src_ready;
    assign load      = src_fire && will_close;

    always_comb
    begin
        blend_group = group_reg;
        if (close_end)
        begin
            blend_group[GROUP_SIZE-1] = src_pixel;
        end
    end

    rgbs_group_blend u_blend (
        .group  (blend_group),
        .next   (src_pixel),
        .pixels (blend_pixels)
    );

    always_comb
    begin
        pos_next  = pos_reg;
        slot_next = slot_reg;
        if (src_fire)
        begin
            if (pos_reg == POS_LAST)
            begin
                pos_next  = '0;
                slot_next = 3'd0;
            end
            else
            begin
                pos_next  = pos_reg + POS_ONE;
                slot_next = (slot_reg == SLOT_LAST) ? 3'd0 : slot_reg + 3'd1;
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        last_next = last_reg;
        bank_next = bank_reg;
        if (out_fire)
        begin
            for (int i = 0; i < GROUP_OUT - 1; i++)
            begin
                bank_next[i] = bank_reg[i+1];
            end
            idx_next = idx_reg + 3'd1;
            if (idx_reg == IDX_LAST)
            begin
                busy_next = 1'b0;
            end
        end
        if (load)
        begin
            bank_next = blend_pixels;
            busy_next = 1'b1;
            idx_next  = 3'd0;
            last_next = close_end || (pos_reg == POS_FULL);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            slot_reg <= 3'd0;
            busy_reg <= 1'b0;
            idx_reg  <= 3'd0;
            last_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            slot_reg <= slot_next;
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bank_reg <= bank_next;
        if (src_fire)
        begin
            group_reg[slot_reg] <= src_pixel;
        end
    end

    assign out_valid  = busy_reg;
    assign out_pixel  = bank_reg[0];
    assign group_last = (idx_reg == IDX_LAST);
    assign line_end   = (idx_reg == IDX_LAST) && last_reg;

endmodule

FILE: hw/rtl/rgbs_group_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbs_group_blend
// Turns a group of five source pixels and the next neighbour into eight
// output pixels at fixed eighth-step phases.
// ----------------------------------------------------------------------------
module rgbs_group_blend (
    input  rgbs_pkg::pixel_t [rgbs_pkg::GROUP_SIZE-1:0] group,
    input  rgbs_pkg::pixel_t                            next,
    output rgbs_pkg::pixel_t [rgbs_pkg::GROUP_OUT-1:0]  pixels
);
    import rgbs_pkg::*;

    always_comb
    begin
        pixels[0] = group[0];
        pixels[1] = blend8(group[0], group[1], W_5_8);
        pixels[2] = blend8(group[1], group[2], W_2_8);
        pixels[3] = blend8(group[1], group[2], W_7_8);
        pixels[4] = blend8(group[2], group[3], W_4_8);
        pixels[5] = blend8(group[3], group[4], W_1_8);
        pixels[6] = blend8(group[3], group[4], W_6_8);
        pixels[7] = blend8(group[4], next, W_3_8);
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RGB555 horizontal 5:8 upscaler. A short table
// of directed source pixels (extremes, flat groups, single channels) is
// followed by random pixels. Every accepted source request updates a local
// model of the group registers and line position. When a group closes, the
// model queues its eight blended pixels. Each output pixel is checked against
// the oldest queued one. Both sides idle in random bursts, except near the
// end of the run.
// ----------------------------------------------------------------------------
module tb;

    import rgbs_pkg::*;

    localparam int LINE_PIXELS = 160;
    localparam int RANDOM_ITEMS = 450;
    localparam int QUIET_TAIL = 60;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 24;
    localparam int DIR_ROWS = 26;
    localparam pixel_t PX_BLACK = 15'h0000;
    localparam pixel_t PX_WHITE = 15'h7FFF;

    // directed row: pixel, whether its closing group is flat, flat value
    typedef struct packed {
        pixel_t pixel;
        logic   flat;
        pixel_t flat_pixel;
    } dir_row_t;

    typedef struct packed {
        pixel_t pixel;
        logic   group_last;
        logic   line_end;
    } scaled_px_t;

    localparam dir_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
        '{15'h0000, 1'b0, 15'h0000},
        '{15'h0000, 1'b0, 15'h0000},
        '{15'h0000, 1'b0, 15'h0000},
        '{15'h0000, 1'b0, 15'h0000},
        '{15'h0000, 1'b0, 15'h0000},
        '{15'h0000, 1'b1, 15'h0000},
        '{15'h7FFF, 1'b0, 15'h0000},
        '{15'h7FFF, 1'b0, 15'h0000},
        '{15'h7FFF, 1'b0, 15'h0000},
        '{15'h7FFF, 1'b0, 15'h0000},
        '{15'h7FFF, 1'b0, 15'h0000},
        '{15'h7FFF, 1'b0, 15'h0000},
        '{15'h7FFF, 1'b0, 15'h0000},
        '{15'h7FFF, 1'b0, 15'h0000},
        '{15'h7FFF, 1'b0, 15'h0000},
        '{15'h7FFF, 1'b1, 15'h7FFF},
        '{15'h0000, 1'b0, 15'h0000},
        '{15'h7FFF, 1'b0, 15'h0000},
        '{15'h0000, 1'b0, 15'h0000},
        '{15'h7FFF, 1'b0, 15'h0000},
        '{15'h0000, 1'b0, 15'h0000},
        '{15'h001F, 1'b0, 15'h0000},
        '{15'h03E0, 1'b0, 15'h0000},
        '{15'h7C00, 1'b0, 15'h0000},
        '{15'h5555, 1'b0, 15'h0000},
        '{15'h2AAA, 1'b0, 15'h0000}
    };

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   src_valid = 1'b0;
    logic   src_ready;
    pixel_t src_pixel = '0;
    logic   out_valid;
    logic   out_ready = 1'b0;
    pixel_t out_pixel;
    logic   group_last;
    logic   line_end;

    pixel_t     stim_px [$];
    bit         stim_flat [$];
    pixel_t     stim_flat_px [$];
    scaled_px_t upscaled_q [$];

    pixel_t group_reg [0:GROUP_SIZE-1];
    int     line_pos = 0;
    int     issued = 0;
    int     taken = 0;
    int     src_gap = 0;
    int     sink_gap = 0;
    int     error_count = 0;
    int     cycle_count = 0;

    rgb555_horizontal_5to8_scaler #(
        .LINE_PIXELS(LINE_PIXELS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .src_valid(src_valid),
        .src_ready(src_ready),
        .src_pixel(src_pixel),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_pixel(out_pixel),
        .group_last(group_last),
        .line_end(line_end)
    );

    always #5 clk = ~clk;

    // floor average of each 5-bit channel on its own
    function automatic pixel_t channel_mean(input pixel_t a, input pixel_t b);
        pixel_t r;
        int     c;
        r = '0;
        for (c = 0; c < 3; c++)
        begin
            r[c*5 +: 5] = 5'((int'(a[c*5 +: 5]) + int'(b[c*5 +: 5])) >> 1);
        end
        return r;
    endfunction

    function automatic pixel_t eighth_blend(input pixel_t a, input pixel_t b, input int w);
        pixel_t h;
        pixel_t r;
        h = channel_mean(a, b);
        case (w)
            1: r = channel_mean(a, channel_mean(a, h));
            2: r = channel_mean(a, h);
            3: r = channel_mean(channel_mean(a, h), h);
            4: r = h;
            5: r = channel_mean(h, channel_mean(h, b));
            6: r = channel_mean(h, b);
            default: r = channel_mean(channel_mean(h, b), b);
        endcase
        if (a == b)
        begin
            r = a;
        end
        return r;
    endfunction

    task automatic queue_group(input pixel_t next, input bit last, input bit flat,
                               input pixel_t flat_px);
        pixel_t     px [0:GROUP_OUT-1];
        scaled_px_t e;
        int         k;
        px[0] = group_reg[0];
        px[1] = eighth_blend(group_reg[0], group_reg[1], 5);
        px[2] = eighth_blend(group_reg[1], group_reg[2], 2);
        px[3] = eighth_blend(group_reg[1], group_reg[2], 7);
        px[4] = eighth_blend(group_reg[2], group_reg[3], 4);
        px[5] = eighth_blend(group_reg[3], group_reg[4], 1);
        px[6] = eighth_blend(group_reg[3], group_reg[4], 6);
        px[7] = eighth_blend(group_reg[4], next, 3);
        for (k = 0; k < GROUP_OUT; k++)
        begin
            e.pixel = flat ? flat_px : px[k];
            e.group_last = (k == GROUP_OUT - 1);
            e.line_end = last && (k == GROUP_OUT - 1);
            upscaled_q.push_back(e);
        end
    endtask

    task automatic upscale_accept(input pixel_t px, input bit flat, input pixel_t flat_px);
        int slot;
        int full_end;
        slot = line_pos % GROUP_SIZE;
        full_end = (LINE_PIXELS / GROUP_SIZE) * GROUP_SIZE;
        if (slot == 0 && line_pos > 0 && line_pos <= full_end)
        begin
            queue_group(px, line_pos == full_end, flat, flat_px);
        end
        group_reg[slot] = px;
        if (line_pos + 1 >= LINE_PIXELS)
        begin
            // line ends on a group boundary: last pixel is its own neighbor
            if (slot == GROUP_SIZE - 1)
            begin
                queue_group(px, 1'b1, flat, flat_px);
            end
            line_pos = 0;
        end
        else
        begin
            line_pos = line_pos + 1;
        end
    endtask

    task automatic check_out_pixel();
        scaled_px_t e;
        if (upscaled_q.size() == 0)
        begin
            $display("%0t: unexpected output pixel %h", $time, out_pixel);
            error_count++;
        end
        else
        begin
            e = upscaled_q.pop_front();
            if (out_pixel !== e.pixel)
            begin
                $display("%0t: out_pixel expected %h got %h", $time, e.pixel, out_pixel);
                error_count++;
            end
            if (group_last !== e.group_last)
            begin
                $display("%0t: group_last expected %b got %b", $time, e.group_last,
                         group_last);
                error_count++;
            end
            if (line_end !== e.line_end)
            begin
                $display("%0t: line_end expected %b got %b", $time, e.line_end, line_end);
                error_count++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            if (rst_n && src_valid && src_ready)
            begin
                upscale_accept(src_pixel, stim_flat[taken], stim_flat_px[taken]);
                taken = taken + 1;
            end
            if (rst_n && out_valid && out_ready)
            begin
                check_out_pixel();
            end
        end
    end

    // source side: hold a pending request, otherwise idle or present the next one
    always @(negedge clk)
    begin
        if (rst_n && issued == taken)
        begin
            if (src_gap > 0)
            begin
                src_valid <= 1'b0;
                src_gap = src_gap - 1;
            end
            else if (issued < stim_px.size())
            begin
                if (issued + QUIET_TAIL < stim_px.size() && $urandom_range(0, 5) == 0)
                begin
                    src_valid <= 1'b0;
                    src_gap = $urandom_range(1, 13) - 1;
                end
                else
                begin
                    src_valid <= 1'b1;
                    src_pixel <= stim_px[issued];
                    issued = issued + 1;
                end
            end
            else
            begin
                src_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (sink_gap > 0)
            begin
                out_ready <= 1'b0;
                sink_gap = sink_gap - 1;
            end
            else if (taken + QUIET_TAIL < stim_px.size() && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                sink_gap = $urandom_range(1, 13) - 1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int     i;
        int     r;
        pixel_t prev;
        for (i = 0; i < DIR_ROWS; i++)
        begin
            stim_px.push_back(DIR_TABLE[i].pixel);
            stim_flat.push_back(DIR_TABLE[i].flat);
            stim_flat_px.push_back(DIR_TABLE[i].flat_pixel);
        end
        prev = DIR_TABLE[DIR_ROWS-1].pixel;
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            r = $urandom_range(0, 9);
            // repeats give equal neighbors
            if (r < 2)
            begin
                stim_px.push_back(prev);
            end
            else if (r == 2)
            begin
                stim_px.push_back(PX_BLACK);
            end
            else if (r == 3)
            begin
                stim_px.push_back(PX_WHITE);
            end
            else
            begin
                stim_px.push_back(pixel_t'($urandom));
            end
            prev = stim_px[stim_px.size()-1];
            stim_flat.push_back(1'b0);
            stim_flat_px.push_back(PX_BLACK);
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (taken < stim_px.size())
        begin
            @(posedge clk);
        end
        while (upscaled_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (upscaled_q.size() != 0)
        begin
            $display("%0t: %0d output pixels never arrived", $time, upscaled_q.size());
            error_count++;
        end
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/rgbs_pkg.sv
hw/rtl/rgbs_group_blend.sv
hw/rtl/rgb555_horizontal_5to8_scaler.sv
tb/tb.sv
